// ----- src/mtic_pkg.sv -----
// Shared types, codes and helpers of the machine trap and interrupt control block.
// No dependencies; used by every other file of the block.
`timescale 1ns / 1ps

package mtic_pkg;

  localparam int unsigned LineCountDefault = 32;
  localparam int unsigned LineIdxW         = 5;
  localparam int unsigned CauseW           = 64;
  localparam int unsigned StatusW          = 7;
  localparam int unsigned MaskW            = 32;
  localparam int unsigned CfgIdxW          = 4;
  localparam int unsigned CfgDataW         = 32;

  // mstatus bit positions within the packed status word
  localparam int unsigned StMie    = 0;
  localparam int unsigned StMpie   = 1;
  localparam int unsigned StMppLo  = 2;
  localparam int unsigned StMppHi  = 3;
  localparam int unsigned StSie    = 4;
  localparam int unsigned StSpie   = 5;
  localparam int unsigned StSpp    = 6;

  localparam logic [CauseW-1:0] CauseFlagRv32 = 64'h0000_0000_8000_0000;
  localparam logic [CauseW-1:0] CauseFlagRv64 = 64'h8000_0000_0000_0000;

  typedef enum logic [2:0] {
    ModeLineUpdate = 3'd0,
    ModeExcTrap    = 3'd1,
    ModeIrqTrap    = 3'd2,
    ModeTrapReturn = 3'd3,
    ModeSetEnables = 3'd4
  } mode_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgIrqEnable = 4'd0,
    CfgWideMode  = 4'd1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    PrivUser  = 2'd0,
    PrivSuper = 2'd1,
    PrivHyper = 2'd2,
    PrivMach  = 2'd3
  } priv_e;

  typedef struct packed {
    logic [2:0]          mode;
    logic [LineIdxW-1:0] irq_number;
    logic                irq_active;
    logic [5:0]          exception_code;
    logic [1:0]          current_privilege;
    logic                machine_enable_value;
    logic                super_enable_value;
  } item_t;

  typedef struct packed {
    logic [CauseW-1:0]  cause_value;
    logic [1:0]         restored_privilege;
    logic               interrupt_request;
    logic [StatusW-1:0] status_bits;
    logic [MaskW-1:0]   pending_mask;
  } result_t;

  typedef struct packed {
    logic [MaskW-1:0] irq_enable;
    logic             wide;
  } cfg_t;

  // lowest set bit; zero when none is set
  function automatic logic [LineIdxW-1:0] lowest_line(input logic [MaskW-1:0] vec);
    logic [LineIdxW-1:0] idx;
    idx = '0;
    for (int i = MaskW - 1; i >= 0; i--) begin
      if (vec[i]) begin
        idx = LineIdxW'(i);
      end
    end
    return idx;
  endfunction

endpackage

// ----- src/mtic_if.sv -----
// Handshake channels of the trap and interrupt control block: event, result, config.
// Depends on mtic_pkg for widths.
`timescale 1ns / 1ps

interface mtic_event_if;
  logic                          valid;
  logic                          ready;
  logic [2:0]                    mode;
  logic [mtic_pkg::LineIdxW-1:0] irq_number;
  logic                          irq_active;
  logic [5:0]                    exception_code;
  logic [1:0]                    current_privilege;
  logic                          machine_enable_value;
  logic                          super_enable_value;

  modport source (
    output valid, mode, irq_number, irq_active, exception_code, current_privilege,
           machine_enable_value, super_enable_value,
    input  ready
  );
  modport sink (
    input  valid, mode, irq_number, irq_active, exception_code, current_privilege,
           machine_enable_value, super_enable_value,
    output ready
  );
endinterface

interface mtic_result_if;
  logic                          valid;
  logic                          ready;
  logic [mtic_pkg::CauseW-1:0]   cause_value;
  logic [1:0]                    restored_privilege;
  logic                          interrupt_request;
  logic [mtic_pkg::StatusW-1:0]  status_bits;
  logic [mtic_pkg::MaskW-1:0]    pending_mask;

  modport source (
    output valid, cause_value, restored_privilege, interrupt_request, status_bits,
           pending_mask,
    input  ready
  );
  modport sink (
    input  valid, cause_value, restored_privilege, interrupt_request, status_bits,
           pending_mask,
    output ready
  );
endinterface

interface mtic_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [mtic_pkg::CfgIdxW-1:0]  index;
  logic [mtic_pkg::CfgDataW-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- src/mtic_in_stage.sv -----
// Input register of the trap and interrupt control block.
// Depends on mtic_pkg and mtic_event_if.
`timescale 1ns / 1ps

module mtic_in_stage (
  input  logic             clk_i,
  input  logic             rst_ni,
  mtic_event_if.sink       event_i,
  input  logic             advance_i,
  output logic             item_valid_o,
  output mtic_pkg::item_t  item_o
);

  logic            valid_q;
  logic            valid_d;
  mtic_pkg::item_t item_q;
  logic            take;

  assign event_i.ready = !valid_q || advance_i;
  assign take          = event_i.valid && event_i.ready;

  always_comb begin
    valid_d = valid_q;
    if (take) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      item_q.mode                 <= event_i.mode;
      item_q.irq_number           <= event_i.irq_number;
      item_q.irq_active           <= event_i.irq_active;
      item_q.exception_code       <= event_i.exception_code;
      item_q.current_privilege    <= event_i.current_privilege;
      item_q.machine_enable_value <= event_i.machine_enable_value;
      item_q.super_enable_value   <= event_i.super_enable_value;
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;

endmodule

// ----- src/mtic_trap_unit.sv -----
// Pending lines, mstatus bits and cause word, with their per-word update logic.
// Depends on mtic_pkg.
`timescale 1ns / 1ps

module mtic_trap_unit #(
  parameter int unsigned LINE_COUNT = mtic_pkg::LineCountDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              advance_i,
  input  mtic_pkg::item_t   item_i,
  input  mtic_pkg::cfg_t    cfg_i,
  output mtic_pkg::result_t result_o
);

  logic [LINE_COUNT-1:0]                pending_q, pending_d;
  logic [mtic_pkg::StatusW-1:0]         status_q, status_d;
  logic [mtic_pkg::CauseW-1:0]          cause_q, cause_d;
  logic [1:0]                           restored;
  logic [LINE_COUNT-1:0]                active_now, active_next;
  logic [mtic_pkg::CauseW-1:0]          irq_cause;

  assign active_now = cfg_i.irq_enable[LINE_COUNT-1:0] & pending_q;
  assign irq_cause  = mtic_pkg::CauseW'(mtic_pkg::lowest_line(mtic_pkg::MaskW'(active_now)))
                    | (cfg_i.wide ? mtic_pkg::CauseFlagRv64 : mtic_pkg::CauseFlagRv32);

  always_comb begin
    pending_d = pending_q;
    status_d  = status_q;
    cause_d   = cause_q;
    restored  = 2'd0;
    case (mtic_pkg::mode_e'(item_i.mode))
      mtic_pkg::ModeLineUpdate: begin
        for (int i = 0; i < int'(LINE_COUNT); i++) begin
          if (item_i.irq_number == mtic_pkg::LineIdxW'(i)) begin
            pending_d[i] = item_i.irq_active;
          end
        end
      end
      mtic_pkg::ModeExcTrap, mtic_pkg::ModeIrqTrap: begin
        cause_d = (item_i.mode == mtic_pkg::ModeIrqTrap) ? irq_cause
                                                         : mtic_pkg::CauseW'(item_i.exception_code);
        status_d[mtic_pkg::StMpie]                      = status_q[mtic_pkg::StMie];
        status_d[mtic_pkg::StMie]                       = 1'b0;
        status_d[mtic_pkg::StMppHi:mtic_pkg::StMppLo]   = item_i.current_privilege;
      end
      mtic_pkg::ModeTrapReturn: begin
        if (item_i.current_privilege == mtic_pkg::PrivMach) begin
          restored                                    = status_q[mtic_pkg::StMppHi:mtic_pkg::StMppLo];
          status_d[mtic_pkg::StMppHi:mtic_pkg::StMppLo] = 2'd0;
          status_d[mtic_pkg::StMie]                   = status_q[mtic_pkg::StMpie];
          status_d[mtic_pkg::StMpie]                  = 1'b1;
        end else if (item_i.current_privilege == mtic_pkg::PrivSuper) begin
          restored                    = {1'b0, status_q[mtic_pkg::StSpp]};
          status_d[mtic_pkg::StSpp]   = 1'b0;
          status_d[mtic_pkg::StSie]   = status_q[mtic_pkg::StSpie];
          status_d[mtic_pkg::StSpie]  = 1'b1;
        end
      end
      mtic_pkg::ModeSetEnables: begin
        status_d[mtic_pkg::StMie] = item_i.machine_enable_value;
        status_d[mtic_pkg::StSie] = item_i.super_enable_value;
      end
      default: begin
      end
    endcase
  end

  assign active_next = cfg_i.irq_enable[LINE_COUNT-1:0] & pending_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
      status_q  <= '0;
      cause_q   <= '0;
    end else if (advance_i) begin
      pending_q <= pending_d;
      status_q  <= status_d;
      cause_q   <= cause_d;
    end
  end

  assign result_o.cause_value        = cause_d;
  assign result_o.restored_privilege = restored;
  assign result_o.interrupt_request  = (|active_next) && status_d[mtic_pkg::StMie];
  assign result_o.status_bits        = status_d;
  assign result_o.pending_mask       = mtic_pkg::MaskW'(pending_d);

endmodule

// ----- src/machine_trap_interrupt_control_unit.sv -----
// Top level of the machine trap and interrupt control block.
// Depends on mtic_pkg, the channel interfaces, mtic_in_stage and mtic_trap_unit.
`timescale 1ns / 1ps

// One event word in, one result word out. A word passes through an input
// register and then a result register; a new word can be taken every cycle
// while results are taken. The event channel's ready follows the result
// channel's ready in the same cycle. Configuration writes are always taken.
module machine_trap_interrupt_control_unit #(
  parameter int unsigned LINE_COUNT = mtic_pkg::LineCountDefault
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  mtic_event_if.sink    event_i,
  mtic_result_if.source result_o,
  mtic_cfg_if.sink      cfg_i
);

  logic              item_valid;
  mtic_pkg::item_t   item;
  logic              advance;
  mtic_pkg::result_t res;
  mtic_pkg::result_t res_q;
  logic              res_valid_q, res_valid_d;
  mtic_pkg::cfg_t    cfg_q;

  assign advance = item_valid && (!res_valid_q || result_o.ready);

  mtic_in_stage u_in_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .event_i      (event_i),
    .advance_i    (advance),
    .item_valid_o (item_valid),
    .item_o       (item)
  );

  mtic_trap_unit #(
    .LINE_COUNT (LINE_COUNT)
  ) u_trap_unit (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .item_i    (item),
    .cfg_i     (cfg_q),
    .result_o  (res)
  );

  // configuration registers
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_i.valid) begin
      case (mtic_pkg::cfg_idx_e'(cfg_i.index))
        mtic_pkg::CfgIrqEnable: cfg_q.irq_enable <= cfg_i.data;
        mtic_pkg::CfgWideMode:  cfg_q.wide       <= cfg_i.data[0];
        default: begin
        end
      endcase
    end
  end

  // result register
  always_comb begin
    res_valid_d = res_valid_q;
    if (advance) begin
      res_valid_d = 1'b1;
    end else if (result_o.ready) begin
      res_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res;
    end
  end

  assign result_o.valid              = res_valid_q;
  assign result_o.cause_value        = res_q.cause_value;
  assign result_o.restored_privilege = res_q.restored_privilege;
  assign result_o.interrupt_request  = res_q.interrupt_request;
  assign result_o.status_bits        = res_q.status_bits;
  assign result_o.pending_mask       = res_q.pending_mask;

endmodule

// ----- src/mtic_checker.sv -----
// Port-level checks of the trap and interrupt control block, bound to its top level.
// Depends on mtic_pkg and machine_trap_interrupt_control_unit.
`timescale 1ns / 1ps

module mtic_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          res_valid_i,
  input logic                          res_ready_i,
  input logic                          irq_req_i,
  input logic [mtic_pkg::StatusW-1:0]  status_i,
  input logic [mtic_pkg::MaskW-1:0]    pending_i,
  input logic [mtic_pkg::CauseW-1:0]   cause_i
);

  // no result word straight out of reset
  assert property (@(posedge clk_i) !rst_ni |-> !res_valid_i)
    else $error("result valid during reset");

  // a request needs MIE set
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_i && irq_req_i) |-> status_i[mtic_pkg::StMie])
    else $error("interrupt request with MIE clear");

  // a request needs some pending line
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_i && irq_req_i) |-> (pending_i != '0))
    else $error("interrupt request with no pending line");

  // stalled word holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_i && !res_ready_i) |=> (res_valid_i && $stable(cause_i)
                                       && $stable(status_i) && $stable(pending_i)))
    else $error("stalled result word changed");

endmodule

bind machine_trap_interrupt_control_unit mtic_checker u_mtic_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .res_valid_i (result_o.valid),
  .res_ready_i (result_o.ready),
  .irq_req_i   (result_o.interrupt_request),
  .status_i    (result_o.status_bits),
  .pending_i   (result_o.pending_mask),
  .cause_i     (result_o.cause_value)
);

// ----- test/mtic_result_checker.sv -----
// Result checker for the machine trap and interrupt control block: predicts each
// result word from the accepted event words and register writes, and compares.
// Depends on mtic_pkg and the channel interfaces in mtic_if.
`timescale 1ns / 1ps

module mtic_result_checker
  import mtic_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  mtic_event_if  event_i,
  mtic_result_if result_i,
  mtic_cfg_if    cfg_i,
  output int     error_count_o,
  output int     words_waiting_o
);

  logic [MaskW-1:0]   irq_enable;
  logic               wide_xlen;
  logic [MaskW-1:0]   line_pending;
  logic [StatusW-1:0] mstatus;
  logic [CauseW-1:0]  cause_reg;

  result_t expected_results[$];
  result_t want;
  item_t   seen_event;

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] wanted);
    $display("%0t: %s: got %h, expected %h", $time, what, got, wanted);
    error_count_o++;
  endtask

  // MIE moves to MPIE, MIE cleared, trapping privilege kept in MPP
  function automatic logic [StatusW-1:0] trap_entry(input logic [StatusW-1:0] s,
                                                    input logic [1:0] priv);
    s[StMpie]          = s[StMie];
    s[StMie]           = 1'b0;
    s[StMppHi:StMppLo] = priv;
    return s;
  endfunction

  function automatic result_t predict_trap_event(input item_t it);
    result_t            r;
    logic [MaskW-1:0]   live;
    logic [StatusW-1:0] s;
    logic [LineIdxW-1:0] line;
    logic               found;
    r     = '0;
    s     = mstatus;
    live  = irq_enable & line_pending;
    line  = '0;
    found = 1'b0;
    case (it.mode)
      ModeLineUpdate: line_pending[it.irq_number] = it.irq_active;
      ModeExcTrap: begin
        cause_reg = {{(CauseW-6){1'b0}}, it.exception_code};
        s = trap_entry(s, it.current_privilege);
      end
      ModeIrqTrap: begin
        for (int i = 0; i < MaskW; i++) begin
          if (live[i] && !found) begin
            line  = LineIdxW'(i);
            found = 1'b1;
          end
        end
        cause_reg = {{(CauseW-LineIdxW){1'b0}}, line} |
                    (wide_xlen ? CauseFlagRv64 : CauseFlagRv32);
        s = trap_entry(s, it.current_privilege);
      end
      ModeTrapReturn: begin
        if (it.current_privilege == PrivMach) begin
          r.restored_privilege = s[StMppHi:StMppLo];
          s[StMie]             = s[StMpie];
          s[StMpie]            = 1'b1;
          s[StMppHi:StMppLo]   = 2'b00;
        end else if (it.current_privilege == PrivSuper) begin
          r.restored_privilege = {1'b0, s[StSpp]};
          s[StSie]             = s[StSpie];
          s[StSpie]            = 1'b1;
          s[StSpp]             = 1'b0;
        end
      end
      ModeSetEnables: begin
        s[StMie] = it.machine_enable_value;
        s[StSie] = it.super_enable_value;
      end
      default: ;
    endcase
    mstatus               = s;
    live                  = irq_enable & line_pending;
    r.cause_value         = cause_reg;
    r.interrupt_request   = (|live) && s[StMie];
    r.status_bits         = s;
    r.pending_mask        = line_pending;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      irq_enable      = '0;
      wide_xlen       = 1'b0;
      line_pending    = '0;
      mstatus         = '0;
      cause_reg       = '0;
      expected_results.delete();
      error_count_o   = 0;
      words_waiting_o = 0;
    end else begin
      if (result_i.valid && result_i.ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result word with no event waiting", result_i.cause_value, '0);
        end else begin
          want = expected_results.pop_front();
          if (result_i.cause_value !== want.cause_value)
            report_mismatch("cause_value", result_i.cause_value, want.cause_value);
          if (result_i.restored_privilege !== want.restored_privilege)
            report_mismatch("restored_privilege", 64'(result_i.restored_privilege),
                            64'(want.restored_privilege));
          if (result_i.interrupt_request !== want.interrupt_request)
            report_mismatch("interrupt_request", 64'(result_i.interrupt_request),
                            64'(want.interrupt_request));
          if (result_i.status_bits !== want.status_bits)
            report_mismatch("status_bits", 64'(result_i.status_bits),
                            64'(want.status_bits));
          if (result_i.pending_mask !== want.pending_mask)
            report_mismatch("pending_mask", 64'(result_i.pending_mask),
                            64'(want.pending_mask));
        end
      end
      if (cfg_i.valid && cfg_i.ready) begin
        case (cfg_i.index)
          CfgIrqEnable: irq_enable = cfg_i.data;
          CfgWideMode:  wide_xlen  = cfg_i.data[0];
          default: ;
        endcase
      end
      if (event_i.valid && event_i.ready) begin
        seen_event.mode                 = event_i.mode;
        seen_event.irq_number           = event_i.irq_number;
        seen_event.irq_active           = event_i.irq_active;
        seen_event.exception_code       = event_i.exception_code;
        seen_event.current_privilege    = event_i.current_privilege;
        seen_event.machine_enable_value = event_i.machine_enable_value;
        seen_event.super_enable_value   = event_i.super_enable_value;
        expected_results.push_back(predict_trap_event(seen_event));
      end
      words_waiting_o = expected_results.size();
    end
  end

endmodule

// ----- test/machine_trap_interrupt_control_unit_tb.sv -----
// Testbench top for machine_trap_interrupt_control_unit: drives event words and
// register writes, varies back-pressure, and reports the verdict.
// Depends on mtic_pkg, mtic_if, the block itself and mtic_result_checker.
`timescale 1ns / 1ps

module machine_trap_interrupt_control_unit_tb;
  import mtic_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni;

  always #5 clk_i = ~clk_i;

  mtic_event_if  event_ch ();
  mtic_result_if result_ch ();
  mtic_cfg_if    cfg_ch ();

  int error_count;
  int words_waiting;
  int send_idle_pct = 18;
  int take_idle_pct = 53;
  int events_sent   = 0;

  machine_trap_interrupt_control_unit i_dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .event_i  (event_ch),
    .result_o (result_ch),
    .cfg_i    (cfg_ch)
  );

  mtic_result_checker i_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .event_i         (event_ch),
    .result_i        (result_ch),
    .cfg_i           (cfg_ch),
    .error_count_o   (error_count),
    .words_waiting_o (words_waiting)
  );

  always @(posedge clk_i) begin
    result_ch.ready <= ($urandom_range(99) >= take_idle_pct);
  end

  function automatic item_t make_event(input logic [2:0] mode, input logic [4:0] irq,
                                       input logic act, input logic [5:0] code,
                                       input logic [1:0] priv, input logic men,
                                       input logic sen);
    item_t it;
    it.mode                 = mode;
    it.irq_number           = irq;
    it.irq_active           = act;
    it.exception_code       = code;
    it.current_privilege    = priv;
    it.machine_enable_value = men;
    it.super_enable_value   = sen;
    return it;
  endfunction

  // mostly line updates, traps and proper MRET/SRET; a few unused modes
  function automatic item_t random_event();
    item_t it;
    int    pick;
    it = make_event(ModeLineUpdate, 5'($urandom_range(31)), 1'($urandom_range(1)),
                    6'($urandom_range(63)), 2'($urandom_range(3)),
                    1'($urandom_range(1)), 1'($urandom_range(1)));
    pick = $urandom_range(99);
    if (pick < 35) begin
      it.irq_active = ($urandom_range(9) < 7);
    end else if (pick < 47) begin
      it.mode = ModeExcTrap;
    end else if (pick < 62) begin
      it.mode = ModeIrqTrap;
    end else if (pick < 78) begin
      it.mode = ModeTrapReturn;
      if ($urandom_range(4) != 0)
        it.current_privilege = $urandom_range(1) ? PrivMach : PrivSuper;
    end else if (pick < 93) begin
      it.mode = ModeSetEnables;
    end else begin
      it.mode = ModeSetEnables + 3'($urandom_range(1, 3));
    end
    return it;
  endfunction

  task automatic send_event(input item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      event_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    event_ch.valid                <= 1'b1;
    event_ch.mode                 <= it.mode;
    event_ch.irq_number           <= it.irq_number;
    event_ch.irq_active           <= it.irq_active;
    event_ch.exception_code       <= it.exception_code;
    event_ch.current_privilege    <= it.current_privilege;
    event_ch.machine_enable_value <= it.machine_enable_value;
    event_ch.super_enable_value   <= it.super_enable_value;
    @(posedge clk_i);
    while (!event_ch.ready) @(posedge clk_i);
    events_sent++;
  endtask

  task automatic wait_for_results();
    event_ch.valid <= 1'b0;
    do @(posedge clk_i); while (words_waiting != 0);
  endtask

  // both registers back to back; upper data bits of the mode write are don't-care
  task automatic write_config(input logic [MaskW-1:0] mask, input logic wide);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= CfgIrqEnable;
    cfg_ch.data  <= mask;
    @(posedge clk_i);
    while (!cfg_ch.ready) @(posedge clk_i);
    cfg_ch.index <= CfgWideMode;
    cfg_ch.data  <= {31'($urandom()), wide};
    @(posedge clk_i);
    while (!cfg_ch.ready) @(posedge clk_i);
    cfg_ch.valid <= 1'b0;
  endtask

  initial begin
    logic [2:0] unused_mode;
    event_ch.valid                = 1'b0;
    event_ch.mode                 = ModeLineUpdate;
    event_ch.irq_number           = '0;
    event_ch.irq_active           = 1'b0;
    event_ch.exception_code       = '0;
    event_ch.current_privilege    = PrivUser;
    event_ch.machine_enable_value = 1'b0;
    event_ch.super_enable_value   = 1'b0;
    cfg_ch.valid                  = 1'b0;
    cfg_ch.index                  = CfgIrqEnable;
    cfg_ch.data                   = '0;
    rst_ni                        = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: nothing enabled, 32-bit cause
    send_event(make_event(ModeLineUpdate, 5'd31, 1'b1, '0, PrivUser, 1'b0, 1'b0));
    send_event(make_event(ModeLineUpdate, 5'd0, 1'b1, '0, PrivUser, 1'b0, 1'b0));
    send_event(make_event(ModeIrqTrap, '0, 1'b0, '0, PrivMach, 1'b0, 1'b0));
    send_event(make_event(ModeExcTrap, '0, 1'b0, 6'h3f, PrivUser, 1'b0, 1'b0));
    send_event(make_event(ModeExcTrap, '0, 1'b0, 6'h00, PrivHyper, 1'b0, 1'b0));
    send_event(make_event(ModeSetEnables, '0, 1'b0, '0, PrivUser, 1'b1, 1'b1));
    send_event(make_event(ModeExcTrap, '0, 1'b0, 6'h05, PrivSuper, 1'b0, 1'b0));
    send_event(make_event(ModeTrapReturn, '0, 1'b0, '0, PrivMach, 1'b0, 1'b0));
    send_event(make_event(ModeTrapReturn, '0, 1'b0, '0, PrivSuper, 1'b0, 1'b0));
    send_event(make_event(ModeTrapReturn, '0, 1'b0, '0, PrivUser, 1'b0, 1'b0));
    send_event(make_event(ModeTrapReturn, '0, 1'b0, '0, PrivHyper, 1'b0, 1'b0));
    unused_mode = ModeSetEnables;
    repeat (3) begin
      unused_mode++;
      send_event(make_event(unused_mode, '1, 1'b1, '1, PrivMach, 1'b1, 1'b1));
    end
    send_event(make_event(ModeLineUpdate, 5'd0, 1'b0, '0, PrivUser, 1'b0, 1'b0));
    wait_for_results();

    // every line enabled, 64-bit cause
    write_config('1, 1'b1);
    send_event(make_event(ModeSetEnables, '0, 1'b0, '0, PrivUser, 1'b1, 1'b0));
    send_event(make_event(ModeIrqTrap, '0, 1'b0, '0, PrivSuper, 1'b0, 1'b0));
    send_event(make_event(ModeLineUpdate, 5'd4, 1'b1, '0, PrivUser, 1'b0, 1'b0));
    send_event(make_event(ModeIrqTrap, '0, 1'b0, '0, PrivMach, 1'b0, 1'b0));
    send_event(make_event(ModeTrapReturn, '0, 1'b0, '0, PrivMach, 1'b0, 1'b0));
    send_event(make_event(ModeSetEnables, '0, 1'b0, '0, PrivUser, 1'b0, 1'b1));
    send_event(make_event(ModeLineUpdate, 5'd31, 1'b0, '0, PrivUser, 1'b0, 1'b0));
    send_event(make_event(ModeLineUpdate, 5'd4, 1'b0, '0, PrivUser, 1'b0, 1'b0));

    for (int phase = 0; phase < 6; phase++) begin
      wait_for_results();
      case (phase)
        0:       write_config('1, 1'b0);
        1:       write_config('0, 1'b1);
        2:       write_config($urandom(), 1'b1);
        3:       write_config(32'h1 << $urandom_range(31), 1'b0);
        4:       write_config($urandom() & $urandom(), 1'($urandom_range(1)));
        default: write_config(32'h8000_0000, 1'b1);
      endcase
      if (phase < 2) begin
        send_idle_pct = 18;
        take_idle_pct = 53;
      end else if (phase < 4) begin
        send_idle_pct = 53;
        take_idle_pct = 18;
      end else begin
        send_idle_pct = 0;
        take_idle_pct = 0;
      end
      repeat (63) send_event(random_event());
    end

    wait_for_results();
    repeat (4) @(posedge clk_i);
    $display("%0d event words checked over eight register settings,", events_sent);
    $display("with sender-heavy, receiver-heavy and no back-pressure idling");
    if (error_count == 0) begin
      $display("machine_trap_interrupt_control_unit_tb: clean");
    end else begin
      $display("machine_trap_interrupt_control_unit_tb: errors");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("machine_trap_interrupt_control_unit_tb: errors");
    $finish;
  end

endmodule
